### src/mtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and codes of the timer table
// Holds the input and result codes, the beat widths and the layout of one
// table entry as kept in the entry memory.
// ----------------------------------------------------------------------------
package mtt_pkg;

	// Input operation codes, carried on s_tuser
	localparam logic [1:0] FUNC_REG   = 2'd0;
	localparam logic [1:0] FUNC_UNREG = 2'd1;
	localparam logic [1:0] FUNC_RST   = 2'd2;
	localparam logic [1:0] FUNC_TICK  = 2'd3;

	// Result kinds, carried on m_tuser
	localparam logic [1:0] KIND_REG  = 2'd0;
	localparam logic [1:0] KIND_ID   = 2'd1;
	localparam logic [1:0] KIND_EXP  = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	// Field widths
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned TIME_W = 31;
	localparam int unsigned CNT_W  = 32;

	// Beat widths, padded to whole bytes
	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 8;

	// One table entry
	typedef struct packed {
		logic                    periodic;
		logic [TIME_W-1:0]       period;
		logic signed [CNT_W-1:0] count;
	} entry_t;

endpackage

### src/multi_timer_table.sv
`timescale 1ns / 1ps
// Register searches the live bits one slot at a time; unregister looks up the given
// slot, and reset reads the slot's entry from memory, then writes it back.
// Tick: a free slot is skipped; a live slot is read from memory, then updated and
// written back; the done beat comes last.
// One item is in work at a time; the result register lets a beat wait downstream.
// Reset clears the live bits, the sequencer and the result register at once.
// ----------------------------------------------------------------------------
// multi_timer_table: table of periodic and one-shot timers
// Register, unregister, reset and tick operations over a slot table whose
// periods and counts lie in a synchronous memory; a tick walks every slot
// and reports expiries in ascending slot order, then a done beat.
// ----------------------------------------------------------------------------
module multi_timer_table #(
	parameter int unsigned MAX_TIMERS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// timer_id[3:0], initial_delay[34:4], period[65:35], persistent[66],
	// elapsed[97:67], zero padding above
	input  logic [mtt_pkg::IN_DATA_W-1:0]    s_tdata,
	// func[1:0]
	input  logic [mtt_pkg::FUNC_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot[3:0], ok[4], zero padding above
	output logic [mtt_pkg::OUT_DATA_W-1:0]   m_tdata,
	// kind[1:0]
	output logic [mtt_pkg::FUNC_W-1:0]       m_tuser,
	// last
	output logic                             m_tlast
);

	localparam int unsigned IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int unsigned SLOT_W = mtt_pkg::SLOT_W;
	localparam int unsigned TIME_W = mtt_pkg::TIME_W;
	localparam int unsigned CNT_W  = mtt_pkg::CNT_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TIMERS - 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_ID   = 3'd2;
	localparam logic [2:0] ST_RSWB = 3'd3;
	localparam logic [2:0] ST_TKRD = 3'd4;
	localparam logic [2:0] ST_TKWB = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]              state_q, state_d;
	logic [IDX_W-1:0]        idx_q, idx_d;
	logic [MAX_TIMERS-1:0]   live_q;
	logic                    live_set, live_clr;
	logic [IDX_W-1:0]        live_idx;

	// Latched input beat
	logic [1:0]              func_q;
	logic [SLOT_W-1:0]       id_q;
	logic [TIME_W-1:0]       delay_q, per_q, el_q;
	logic                    pers_q;

	// Result register
	logic                    out_valid_q;
	logic [1:0]              out_kind_q;
	logic [SLOT_W-1:0]       out_slot_q;
	logic                    out_ok_q, out_last_q;
	logic                    out_free;
	logic                    ld, ld_ok, ld_last;
	logic [1:0]              ld_kind;
	logic [SLOT_W-1:0]       ld_slot;

	// Memory ports
	logic                    mem_we, mem_re;
	logic [IDX_W-1:0]        mem_waddr, mem_raddr;
	mtt_pkg::entry_t         mem_wdata, mem_rdata;

	// Index and slot conversions
	logic [SLOT_W+IDX_W-1:0] id_wide, idx_wide;
	logic [IDX_W-1:0]        id_idx;
	logic [SLOT_W-1:0]       idx_slot;
	logic                    id_hit;

	// Tick arithmetic
	logic signed [CNT_W:0]   sum;
	logic signed [CNT_W-1:0] cnt_sat;
	logic                    expired;
	logic                    accept;

	assign id_wide  = {{IDX_W{1'b0}}, id_q};
	assign id_idx   = id_wide[IDX_W-1:0];
	assign idx_wide = {{SLOT_W{1'b0}}, idx_q};
	assign idx_slot = idx_wide[SLOT_W-1:0];
	assign id_hit   = (32'(id_q) < MAX_TIMERS) && live_q[id_idx];

	// Add elapsed time, saturate at the top of the signed range, compare
	assign sum     = {mem_rdata.count[CNT_W-1], mem_rdata.count}
	                 + $signed({2'b00, el_q});
	assign cnt_sat = (!sum[CNT_W] && sum[CNT_W-1]) ? {1'b0, {(CNT_W-1){1'b1}}}
	                                               : sum[CNT_W-1:0];
	assign expired = cnt_sat >= $signed({1'b0, mem_rdata.period});

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	mtt_ram #(
		.DEPTH (MAX_TIMERS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		live_set  = 1'b0;
		live_clr  = 1'b0;
		live_idx  = idx_q;
		ld        = 1'b0;
		ld_kind   = mtt_pkg::KIND_DONE;
		ld_slot   = '0;
		ld_ok     = 1'b1;
		ld_last   = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_d = '0;
					unique case (s_tuser)
						mtt_pkg::FUNC_REG:  state_d = ST_SCAN;
						mtt_pkg::FUNC_TICK: state_d = ST_TKRD;
						default:            state_d = ST_ID;
					endcase
				end
			end
			ST_SCAN: begin
				if (!live_q[idx_q]) begin
					if (out_free) begin
						mem_we           = 1'b1;
						mem_wdata.periodic = pers_q;
						mem_wdata.period = per_q;
						mem_wdata.count  = $signed({1'b0, per_q}) - $signed({1'b0, delay_q});
						live_set         = 1'b1;
						ld               = 1'b1;
						ld_kind          = mtt_pkg::KIND_REG;
						ld_slot          = idx_slot;
						state_d          = ST_IDLE;
					end
				end else if (idx_q == IDX_LAST) begin
					if (out_free) begin
						ld      = 1'b1;
						ld_kind = mtt_pkg::KIND_REG;
						ld_ok   = 1'b0;
						state_d = ST_IDLE;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_ID: begin
				if (id_hit && func_q == mtt_pkg::FUNC_RST) begin
					mem_re    = 1'b1;
					mem_raddr = id_idx;
					state_d   = ST_RSWB;
				end else if (out_free) begin
					ld       = 1'b1;
					ld_kind  = mtt_pkg::KIND_ID;
					ld_slot  = id_q;
					ld_ok    = id_hit;
					live_clr = id_hit;
					live_idx = id_idx;
					state_d  = ST_IDLE;
				end
			end
			ST_RSWB: begin
				if (out_free) begin
					mem_we          = 1'b1;
					mem_waddr       = id_idx;
					mem_wdata.count = mem_rdata.periodic ? $signed({1'b0, mem_rdata.period})
					                                     : '0;
					ld              = 1'b1;
					ld_kind         = mtt_pkg::KIND_ID;
					ld_slot         = id_q;
					state_d         = ST_IDLE;
				end
			end
			ST_TKRD: begin
				if (live_q[idx_q]) begin
					mem_re  = 1'b1;
					state_d = ST_TKWB;
				end else if (idx_q == IDX_LAST) begin
					state_d = ST_DONE;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_TKWB: begin
				if (!expired || out_free) begin
					// Update the count; on expiry restart or free the slot
					mem_we          = 1'b1;
					mem_wdata.count = expired ? '0 : cnt_sat;
					if (expired) begin
						ld       = 1'b1;
						ld_kind  = mtt_pkg::KIND_EXP;
						ld_slot  = idx_slot;
						ld_last  = 1'b0;
						live_clr = !mem_rdata.periodic;
					end
					if (idx_q == IDX_LAST) begin
						state_d = ST_DONE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ST_TKRD;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = mtt_pkg::KIND_DONE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (live_set) begin
				live_q[live_idx] <= 1'b1;
			end else if (live_clr) begin
				live_q[live_idx] <= 1'b0;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted beat and the pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= s_tuser;
			id_q    <= s_tdata[3:0];
			delay_q <= s_tdata[34:4];
			per_q   <= s_tdata[65:35];
			pers_q  <= s_tdata[66];
			el_q    <= s_tdata[97:67];
		end
		if (ld) begin
			out_kind_q <= ld_kind;
			out_slot_q <= ld_slot;
			out_ok_q   <= ld_ok;
			out_last_q <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_ok_q, out_slot_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

### src/mtt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_ram: entry memory of the timer table
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module mtt_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  mtt_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output mtt_pkg::entry_t rdata
);

	mtt_pkg::entry_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### tb/multi_timer_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_table_checker: scoreboard for the timer table
// Watches both stream channels. Every accepted input beat is run through a
// local model of the slot table, and the answers it must produce are queued.
// Every accepted result beat is compared field by field with the oldest
// queued answer. Hands a mismatch count and the number of answers still
// owed to the testbench top.
// ----------------------------------------------------------------------------
module multi_timer_table_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// timer_id[3:0], initial_delay[34:4], period[65:35], persistent[66],
	// elapsed[97:67], zero padding above
	input  logic [mtt_pkg::IN_DATA_W-1:0]   s_tdata,
	// func[1:0]
	input  logic [mtt_pkg::FUNC_W-1:0]      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// slot[3:0], ok[4], zero padding above
	input  logic [mtt_pkg::OUT_DATA_W-1:0]  m_tdata,
	// kind[1:0]
	input  logic [mtt_pkg::FUNC_W-1:0]      m_tuser,
	// last
	input  logic                            m_tlast,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int unsigned FUNC_W    = mtt_pkg::FUNC_W;
	localparam int unsigned SLOT_W    = mtt_pkg::SLOT_W;
	localparam int unsigned TIME_W    = mtt_pkg::TIME_W;
	localparam int unsigned CNT_W     = mtt_pkg::CNT_W;
	localparam int unsigned IN_DATA_W = mtt_pkg::IN_DATA_W;
	localparam int unsigned SLOTS = 16;
	localparam longint      COUNT_TOP = 64'sd2147483647;

	typedef struct packed {
		logic [FUNC_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic              ok;
		logic              last;
	} timer_answer_t;

	// Local copy of the slot table
	logic                    slot_live     [SLOTS];
	logic [TIME_W-1:0]       slot_period   [SLOTS];
	logic signed [CNT_W-1:0] slot_count    [SLOTS];
	logic                    slot_periodic [SLOTS];

	// Answers owed by the block, oldest first
	timer_answer_t owed_answers [$];

	// Queue one owed answer at the back
	task automatic owe_answer(input logic [FUNC_W-1:0] kind,
			input logic [SLOT_W-1:0] slot, input logic ok, input logic last);
		timer_answer_t a;
		a.kind = kind;
		a.slot = slot;
		a.ok   = ok;
		a.last = last;
		owed_answers.insert(owed_answers.size(), a);
	endtask

	// Apply one operation to the table and queue the answers it causes
	task automatic apply_timer_op(input logic [FUNC_W-1:0] func,
			input logic [IN_DATA_W-1:0] beat);
		logic [SLOT_W-1:0] id;
		logic [TIME_W-1:0] delay;
		logic [TIME_W-1:0] per;
		logic              pers;
		logic [TIME_W-1:0] el;
		logic              hit;
		longint            sum;
		int                i;
		int                free_slot;
		id    = beat[3:0];
		delay = beat[34:4];
		per   = beat[65:35];
		pers  = beat[66];
		el    = beat[97:67];
		case (func) inside
			mtt_pkg::FUNC_REG: begin
				// take the lowest free slot, if any
				free_slot = -1;
				for (i = 0; i < SLOTS; i++) begin
					if (free_slot < 0 && !slot_live[i])
						free_slot = i;
				end
				if (free_slot < 0) begin
					owe_answer(mtt_pkg::KIND_REG, '0, 1'b0, 1'b1);
				end else begin
					sum = longint'(per) - longint'(delay);
					slot_live[free_slot]     = 1'b1;
					slot_period[free_slot]   = per;
					slot_periodic[free_slot] = pers;
					slot_count[free_slot]    = sum[CNT_W-1:0];
					owe_answer(mtt_pkg::KIND_REG, free_slot[SLOT_W-1:0], 1'b1, 1'b1);
				end
			end
			mtt_pkg::FUNC_UNREG, mtt_pkg::FUNC_RST: begin
				hit = slot_live[id];
				if (hit) begin
					if (func == mtt_pkg::FUNC_UNREG)
						slot_live[id] = 1'b0;
					else
						slot_count[id] = slot_periodic[id] ? {1'b0, slot_period[id]} : '0;
				end
				owe_answer(mtt_pkg::KIND_ID, id, hit, 1'b1);
			end
			default: begin
				// advance every live timer, saturating at the top of the range
				for (i = 0; i < SLOTS; i++) begin
					if (slot_live[i]) begin
						sum = longint'(slot_count[i]) + longint'(el);
						if (sum > COUNT_TOP)
							sum = COUNT_TOP;
						slot_count[i] = sum[CNT_W-1:0];
						if (sum >= longint'(slot_period[i])) begin
							owe_answer(mtt_pkg::KIND_EXP, i[SLOT_W-1:0], 1'b1, 1'b0);
							if (slot_periodic[i])
								slot_count[i] = '0;
							else
								slot_live[i] = 1'b0;
						end
					end
				end
				owe_answer(mtt_pkg::KIND_DONE, '0, 1'b1, 1'b1);
			end
		endcase
	endtask

	// Predict on input beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		timer_answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_live[i] = 1'b0;
			owed_answers.delete();
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_timer_op(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (owed_answers.size() == 0) begin
					$error("unexpected result beat: kind %0d slot %0d ok %0d last %0d",
						m_tuser, m_tdata[3:0], m_tdata[4], m_tlast);
					mismatches++;
				end else begin
					want = owed_answers.pop_front();
					if (m_tuser !== want.kind) begin
						$error("kind mismatch: expected %0d, actual %0d", want.kind, m_tuser);
						mismatches++;
					end
					if (m_tdata[3:0] !== want.slot) begin
						$error("slot mismatch: expected %0d, actual %0d", want.slot,
							m_tdata[3:0]);
						mismatches++;
					end
					if (m_tdata[4] !== want.ok) begin
						$error("ok mismatch: expected %0d, actual %0d", want.ok, m_tdata[4]);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
						mismatches++;
					end
				end
			end
			outstanding = owed_answers.size();
		end
	end

endmodule

### tb/multi_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_table_tb: testbench for the timer table
// Drives register, unregister, reset and tick operations in bursts, first a
// directed set that fills the table past full and hits the count extremes,
// then random traffic that alternates between filling and draining. The
// result side stalls on a changing pattern, with one long hold-off that
// backs the block up. Checking is done by the scoreboard beside the block.
// ----------------------------------------------------------------------------
module multi_timer_table_tb;

	localparam int unsigned FUNC_W     = mtt_pkg::FUNC_W;
	localparam int unsigned SLOT_W     = mtt_pkg::SLOT_W;
	localparam int unsigned TIME_W     = mtt_pkg::TIME_W;
	localparam int unsigned IN_DATA_W  = mtt_pkg::IN_DATA_W;
	localparam int unsigned OUT_DATA_W = mtt_pkg::OUT_DATA_W;
	localparam int unsigned RANDOM_OPS   = 96;
	localparam int unsigned HOLD_CYCLES  = 250;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [FUNC_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [FUNC_W-1:0]      m_tuser;
	logic                   m_tlast;
	int                     mismatches;
	int                     outstanding;
	int unsigned            cycle_count = 0;
	int                     burst_left = 0;
	logic                   hold_off_req = 1'b0;

	always #2 clk = ~clk;

	multi_timer_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	multi_timer_table_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("multi_timer_table_tb: FAIL");
			$finish;
		end
	end

	// Pick a time value, leaning towards the edges of the range
	function automatic logic [TIME_W-1:0] rand_span();
		case ($urandom_range(0, 7)) inside
			0: rand_span = '0;
			1: rand_span = TIME_TOP;
			2: rand_span = TIME_W'($urandom_range(0, 20));
			3, 4: rand_span = TIME_W'($urandom_range(0, 2000));
			default: rand_span = TIME_W'($urandom());
		endcase
	endfunction

	// Offer one beat, with a random gap at the start of each burst
	task automatic send_op(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] id,
			input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] per,
			input logic pers, input logic [TIME_W-1:0] el);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {6'b0, el, pers, per, delay, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result side: stall on a changing pattern, with one long hold-off
	initial begin
		int mode;
		int mode_left;
		int phase;
		logic hold_done;
		mode_left = 0;
		phase = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			phase++;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (phase % 6) < 3;
			endcase
		end
	end

	// Stimulus and verdict
	initial begin
		int n;
		int r;
		logic [FUNC_W-1:0] func;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = mtt_pkg::FUNC_REG;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the table at the count extremes, then register once past full
		send_op(mtt_pkg::FUNC_REG, 4'hF, '0, '0, 1'b1, TIME_TOP);
		send_op(mtt_pkg::FUNC_REG, '0, TIME_TOP, TIME_TOP, 1'b0, '0);
		send_op(mtt_pkg::FUNC_REG, 4'h5, TIME_TOP, '0, 1'b1, '0);
		send_op(mtt_pkg::FUNC_REG, 4'hA, '0, TIME_TOP, 1'b1, '0);
		for (n = 4; n < 17; n++)
			send_op(mtt_pkg::FUNC_REG, SLOT_W'($urandom()),
				TIME_W'($urandom_range(0, 200000)),
				TIME_W'($urandom_range(100000, 300000)), 1'($urandom_range(0, 1)),
				TIME_W'($urandom()));

		// live and dead slots for unregister and reset, both timer kinds
		send_op(mtt_pkg::FUNC_UNREG, 4'hF, TIME_W'($urandom()), TIME_W'($urandom()), 1'b1,
			TIME_W'($urandom()));
		send_op(mtt_pkg::FUNC_UNREG, 4'hF, TIME_W'($urandom()), TIME_W'($urandom()), 1'b0,
			TIME_W'($urandom()));
		send_op(mtt_pkg::FUNC_RST, 4'h0, TIME_W'($urandom()), TIME_W'($urandom()), 1'b0,
			TIME_W'($urandom()));
		send_op(mtt_pkg::FUNC_RST, 4'h1, TIME_W'($urandom()), TIME_W'($urandom()), 1'b1,
			TIME_W'($urandom()));
		send_op(mtt_pkg::FUNC_RST, 4'hF, TIME_W'($urandom()), TIME_W'($urandom()), 1'b1,
			TIME_W'($urandom()));

		// zero tick, then a full-range tick that saturates the top count
		send_op(mtt_pkg::FUNC_TICK, SLOT_W'($urandom()), TIME_W'($urandom()),
			TIME_W'($urandom()), 1'b1, '0);
		send_op(mtt_pkg::FUNC_TICK, SLOT_W'($urandom()), TIME_W'($urandom()),
			TIME_W'($urandom()), 1'b0, TIME_TOP);

		// random traffic, alternating fill-heavy and drain-heavy stretches
		hold_off_req = 1'b1;
		for (n = 0; n < RANDOM_OPS; n++) begin
			r = $urandom_range(0, 99);
			if ((n / 20) % 2 == 0)
				func = r < 50 ? mtt_pkg::FUNC_REG : r < 60 ? mtt_pkg::FUNC_UNREG
					: r < 75 ? mtt_pkg::FUNC_RST : mtt_pkg::FUNC_TICK;
			else
				func = r < 20 ? mtt_pkg::FUNC_REG : r < 45 ? mtt_pkg::FUNC_UNREG
					: r < 65 ? mtt_pkg::FUNC_RST : mtt_pkg::FUNC_TICK;
			send_op(func, SLOT_W'($urandom_range(0, 15)), rand_span(), rand_span(),
				1'($urandom_range(0, 1)), rand_span());
		end
		s_tvalid <= 1'b0;

		// wait for every owed answer, then let stray beats show up
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("multi_timer_table_tb: PASS");
		else
			$display("multi_timer_table_tb: FAIL");
		$finish;
	end

endmodule
